>>> design/bai_pkg.sv
// bai_pkg: field widths, request and status codes, and the per-cell command
// type for the bounded array. No dependencies; every other file imports it.
package bai_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

>>> design/bai_req_if.sv
// bai_req_if: valid/ready request channel of the bounded array
// depends on bai_pkg for field widths
interface bai_req_if;
  import bai_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] word_in;

  modport source (output valid, req_type, position, word_in, input ready);
  modport sink   (input valid, req_type, position, word_in, output ready);
endinterface

>>> design/bai_rsp_if.sv
// bai_rsp_if: valid/ready result channel of the bounded array
// depends on bai_pkg for field widths
interface bai_rsp_if;
  import bai_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] word_out;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;
  logic                     is_empty;

  modport source (output valid, word_out, status, count, is_empty, input ready);
  modport sink   (input valid, word_out, status, count, is_empty, output ready);
endinterface

>>> design/bai_cell.sv
// bai_cell: one storage slot of the array; loads the new word, its left
// neighbor on an insert shift or its right neighbor on a delete shift
// depends on bai_pkg for cell_cmd_t and WORD_W
module bai_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                              clk_i,
  input  bai_pkg::cell_cmd_t                cmd_i,
  input  logic [IDX_W-1:0]                  tgt_i,
  input  logic signed [bai_pkg::WORD_W-1:0] word_i,
  input  logic signed [bai_pkg::WORD_W-1:0] left_i,
  input  logic signed [bai_pkg::WORD_W-1:0] right_i,
  output logic signed [bai_pkg::WORD_W-1:0] word_o
);
  import bai_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic signed [WORD_W-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (MyIdx == tgt_i) begin
        word_d = word_i;
      end else if (MyIdx > tgt_i) begin
        word_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= tgt_i) begin
        word_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
endmodule

>>> design/bounded_array_insert_delete.sv
// Bounded array of up to DEPTH signed 32-bit words with push, pop, read,
// insert and delete requests. Every request gives one result with a status,
// the count after the request (low five bits) and an empty flag; a failing
// request changes nothing. Words sit in a row of cells that all shift in the
// same cycle. A request is taken only while the result register is empty or
// its result is taken in the same cycle, so a waiting result holds off
// requests, and requests follow back to back whenever results are taken at
// once. The result is registered and shows in the cycle after the request
// transfer.
// depends on bai_pkg, bai_req_if, bai_rsp_if and bai_cell
module bounded_array_insert_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bai_req_if.sink  req_i,
  bai_rsp_if.source rsp_o
);
  import bai_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = ((CntW > POS_W) ? CntW : POS_W) + 1;
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);

  logic [CntW-1:0]          count_d, count_q;
  logic                     rsp_valid_q;
  logic signed [WORD_W-1:0] rsp_word_d, rsp_word_q;
  logic [STATUS_W-1:0]      rsp_status_d, rsp_status_q;
  logic [COUNT_W-1:0]       rsp_count_q;
  logic                     rsp_empty_q;

  logic                     fire;
  logic [CmpW-1:0]          n_ext, p_ext, cnt_nxt, tgt;
  logic [IdxW-1:0]          tgt_idx;
  logic                     rd_sel;
  logic                     full;
  cell_cmd_t                cmd;
  logic signed [WORD_W-1:0] rd_word;
  logic signed [WORD_W-1:0] cell_word [DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  assign n_ext   = CmpW'(count_q);
  assign p_ext   = CmpW'(req_i.position);
  assign full    = n_ext >= DepthC;
  assign tgt_idx = tgt[IdxW-1:0];

  always_comb begin
    cnt_nxt      = n_ext;
    tgt          = p_ext;
    rd_sel       = 1'b0;
    cmd          = '0;
    rsp_status_d = ST_OK;
    case (req_i.req_type)
      REQ_PUSH: begin
        tgt = n_ext;
        if (full) begin
          rsp_status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cnt_nxt = n_ext + 1'b1;
        end
      end
      REQ_POP: begin
        tgt = n_ext - 1'b1;
        if (n_ext == '0) begin
          rsp_status_d = ST_EMPTY;
        end else begin
          cmd.del = 1'b1;
          rd_sel  = 1'b1;
          cnt_nxt = n_ext - 1'b1;
        end
      end
      REQ_READ: begin
        if (p_ext >= n_ext) begin
          rsp_status_d = ST_RANGE;
        end else begin
          rd_sel = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (full) begin
          rsp_status_d = ST_FULL;
        end else if (p_ext > n_ext) begin
          rsp_status_d = ST_RANGE;
        end else begin
          cmd.ins = 1'b1;
          cnt_nxt = n_ext + 1'b1;
        end
      end
      REQ_DELETE: begin
        if (p_ext >= n_ext) begin
          rsp_status_d = ST_RANGE;
        end else begin
          cmd.del = 1'b1;
          cnt_nxt = n_ext - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      cmd = '0;
    end
  end

  assign count_d = cnt_nxt[CntW-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    bai_cell #(
      .IDX_W (IdxW),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .tgt_i   (tgt_idx),
      .word_i  (req_i.word_in),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tgt_idx == IdxW'(i)) begin
        rd_word = rd_word | cell_word[i];
      end
    end
    rsp_word_d = rd_sel ? rd_word : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_word_q   <= rsp_word_d;
      rsp_status_q <= rsp_status_d;
      rsp_count_q  <= cnt_nxt[COUNT_W-1:0];
      rsp_empty_q  <= (cnt_nxt == '0);
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.word_out = rsp_word_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.count    = rsp_count_q;
  assign rsp_o.is_empty = rsp_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= DepthC)
    else $error("element count above capacity");

  a_rsp_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_valid_q)
    else $error("no result after request transfer");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rsp_status_d == ST_FULL) |-> n_ext == DepthC)
    else $error("full status while space left");
endmodule
